@@ hdl/iqr_pkg.sv @@
package iqr_pkg;

   // Field widths of the request and response words
   localparam int CAP_W   = 7;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 6;
   localparam int SLOT_W  = 6;
   localparam int COUNT_W = 7;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   typedef enum logic [1:0] {
      OP_PUT    = 2'd0,
      OP_GET    = 2'd1,
      OP_REMOVE = 2'd2,
      OP_SEEK   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_READ  = 2'd1,
      ST_SHIFT = 2'd2,
      ST_EMIT  = 2'd3
   } state_type;

endpackage

@@ hdl/iqr_store.sv @@
module iqr_store #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [DATA_WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [DATA_WIDTH-1:0]         rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/indexed_queue_with_removal_unit.sv @@
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  req_type, req_entry_value, req_position
// rsp      out        rsp_valid/rsp_stall  rsp_accepted .. rsp_is_exhausted
// csr      in         csr_we               csr_wdata (capacity)
//
// One word at a time. Put, seek and every refused word go from accept to EMIT,
// where the response loads once the output register is free; get passes
// through READ first for the store read. Remove goes through READ, then SHIFT
// for each entry above position, compaction moving one entry per cycle, then EMIT.
// Synchronous reset clears count and cursor, reloads capacity to 64, leaves the store.
// A stalled response holds in its register; req_stall stays high until the next loads.
module indexed_queue_with_removal_unit #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_type,
   input  logic [iqr_pkg::VALUE_W-1:0]   req_entry_value,
   input  logic [iqr_pkg::POS_W-1:0]     req_position,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_accepted,
   output logic [iqr_pkg::VALUE_W-1:0]   rsp_read_value,
   output logic [iqr_pkg::SLOT_W-1:0]    rsp_slot_index,
   output logic [iqr_pkg::COUNT_W-1:0]   rsp_entry_count,
   output logic [iqr_pkg::COUNT_W-1:0]   rsp_cursor,
   output logic                          rsp_is_full,
   output logic                          rsp_is_empty,
   output logic                          rsp_is_exhausted,
   // configuration
   input  logic                          csr_we,
   input  logic [iqr_pkg::CAP_W-1:0]     csr_wdata
);

   // address and count widths follow from DEPTH; the compare width is the larger of the count width and COUNT_W
   localparam int AW     = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int CMP_W  = (CNT_W > iqr_pkg::COUNT_W) ? CNT_W : iqr_pkg::COUNT_W;
   localparam int DW_MAX = (DATA_WIDTH > iqr_pkg::VALUE_W) ? DATA_WIDTH : iqr_pkg::VALUE_W;
   localparam logic [CMP_W-1:0] DEPTH_W = CMP_W'(DEPTH);

   // control state
   iqr_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   cursor_ff, cursor_in;
   logic [iqr_pkg::CAP_W-1:0] cap_ff;
   logic               rsp_valid_ff, rsp_valid_in;

   // per-word working registers
   iqr_pkg::op_type    op_ff, op_in;
   logic [CMP_W-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]   sh_ff, sh_in;
   logic               ok_ff, ok_in;
   logic [DATA_WIDTH-1:0] rd_ff, rd_in;
   logic [iqr_pkg::SLOT_W-1:0] slot_ff, slot_in;

   // response register
   logic               acc_ff, acc_in;
   logic [iqr_pkg::VALUE_W-1:0] rval_ff, rval_in;
   logic [iqr_pkg::SLOT_W-1:0]  rslot_ff, rslot_in;
   logic [iqr_pkg::COUNT_W-1:0] rcount_ff, rcount_in;
   logic [iqr_pkg::COUNT_W-1:0] rcursor_ff, rcursor_in;
   logic               rfull_ff, rfull_in;
   logic               rempty_ff, rempty_in;
   logic               rexh_ff, rexh_in;

   // store port
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [DATA_WIDTH-1:0] mem_wdata;
   logic [AW-1:0]         mem_raddr;
   logic [DATA_WIDTH-1:0] mem_rdata;

   // widened views for compares
   logic [CMP_W-1:0]  count_w, cursor_w, cap_w, eff_w, req_pos_w, pos_p1, sh_p1;
   logic [CNT_W-1:0]  count_dec, sh_m1;
   logic [DW_MAX-1:0] val_ext, rd_ext;
   logic              emit_load;

   assign count_w   = CMP_W'(count_ff);
   assign cursor_w  = CMP_W'(cursor_ff);
   assign cap_w     = CMP_W'(cap_ff);
   assign eff_w     = (cap_w < DEPTH_W) ? cap_w : DEPTH_W;
   assign req_pos_w = CMP_W'(req_position);
   assign pos_p1    = pos_ff + CMP_W'(1);
   assign sh_p1     = CMP_W'(sh_ff) + CMP_W'(1);
   assign sh_m1     = sh_ff - CNT_W'(1);
   assign count_dec = count_ff - CNT_W'(1);
   assign val_ext   = DW_MAX'(req_entry_value);
   assign rd_ext    = DW_MAX'(rd_ff);
   assign emit_load = (state_ff == iqr_pkg::ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   iqr_store #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cursor_in    = cursor_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      sh_in        = sh_ff;
      ok_in        = ok_ff;
      rd_in        = rd_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      acc_in       = acc_ff;
      rval_in      = rval_ff;
      rslot_in     = rslot_ff;
      rcount_in    = rcount_ff;
      rcursor_in   = rcursor_ff;
      rfull_in     = rfull_ff;
      rempty_in    = rempty_ff;
      rexh_in      = rexh_ff;
      mem_we       = 1'b0;
      mem_waddr    = count_ff[AW-1:0];
      mem_wdata    = val_ext[DATA_WIDTH-1:0];
      mem_raddr    = cursor_ff[AW-1:0];

      unique case (state_ff)
         iqr_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in    = iqr_pkg::op_type'(req_type);
               pos_in   = req_pos_w;
               ok_in    = 1'b0;
               rd_in    = '0;
               slot_in  = '0;
               state_in = iqr_pkg::ST_EMIT;
               unique case (iqr_pkg::op_type'(req_type))
                  iqr_pkg::OP_PUT: begin
                     // append at slot = count
                     if (count_w < eff_w) begin
                        mem_we   = 1'b1;
                        slot_in  = count_w[iqr_pkg::SLOT_W-1:0];
                        count_in = count_ff + CNT_W'(1);
                        ok_in    = 1'b1;
                     end
                  end
                  iqr_pkg::OP_GET: begin
                     if (cursor_w < count_w) begin
                        mem_raddr = cursor_ff[AW-1:0];
                        cursor_in = cursor_ff + CNT_W'(1);
                        ok_in     = 1'b1;
                        state_in  = iqr_pkg::ST_READ;
                     end
                  end
                  iqr_pkg::OP_REMOVE: begin
                     if (req_pos_w < count_w) begin
                        mem_raddr = req_pos_w[AW-1:0];
                        ok_in     = 1'b1;
                        state_in  = iqr_pkg::ST_READ;
                     end
                  end
                  iqr_pkg::OP_SEEK: begin
                     if (req_pos_w < eff_w) begin
                        cursor_in = req_pos_w[CNT_W-1:0];
                        ok_in     = 1'b1;
                     end
                  end
               endcase
            end
         end
         iqr_pkg::ST_READ: begin
            // capture the returned entry; for a remove, start compaction
            rd_in    = mem_rdata;
            state_in = iqr_pkg::ST_EMIT;
            if (op_ff == iqr_pkg::OP_REMOVE) begin
               if (pos_p1 < count_w) begin
                  mem_raddr = pos_p1[AW-1:0];
                  sh_in     = pos_p1[CNT_W-1:0];
                  state_in  = iqr_pkg::ST_SHIFT;
               end else begin
                  count_in  = count_dec;
                  cursor_in = (cursor_ff > count_dec) ? count_dec : cursor_ff;
               end
            end
         end
         iqr_pkg::ST_SHIFT: begin
            // entry sh arrives now: drop it one slot lower, fetch the next
            mem_we    = 1'b1;
            mem_waddr = sh_m1[AW-1:0];
            mem_wdata = mem_rdata;
            if (sh_p1 < count_w) begin
               mem_raddr = sh_p1[AW-1:0];
               sh_in     = sh_p1[CNT_W-1:0];
            end else begin
               count_in  = count_dec;
               cursor_in = (cursor_ff > count_dec) ? count_dec : cursor_ff;
               state_in  = iqr_pkg::ST_EMIT;
            end
         end
         iqr_pkg::ST_EMIT: begin
            // load the response word once the output register is free
            if (emit_load) begin
               rsp_valid_in = 1'b1;
               acc_in       = ok_ff;
               rval_in      = rd_ext[iqr_pkg::VALUE_W-1:0];
               rslot_in     = slot_ff;
               rcount_in    = count_w[iqr_pkg::COUNT_W-1:0];
               rcursor_in   = cursor_w[iqr_pkg::COUNT_W-1:0];
               rfull_in     = (count_w >= eff_w);
               rempty_in    = (count_ff == '0);
               rexh_in      = (cursor_w >= count_w);
               state_in     = iqr_pkg::ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= iqr_pkg::ST_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         cap_ff       <= iqr_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            cap_ff <= csr_wdata;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      pos_ff     <= pos_in;
      sh_ff      <= sh_in;
      ok_ff      <= ok_in;
      rd_ff      <= rd_in;
      slot_ff    <= slot_in;
      acc_ff     <= acc_in;
      rval_ff    <= rval_in;
      rslot_ff   <= rslot_in;
      rcount_ff  <= rcount_in;
      rcursor_ff <= rcursor_in;
      rfull_ff   <= rfull_in;
      rempty_ff  <= rempty_in;
      rexh_ff    <= rexh_in;
   end

   assign req_stall        = (state_ff != iqr_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = acc_ff;
   assign rsp_read_value   = rval_ff;
   assign rsp_slot_index   = rslot_ff;
   assign rsp_entry_count  = rcount_ff;
   assign rsp_cursor       = rcursor_ff;
   assign rsp_is_full      = rfull_ff;
   assign rsp_is_empty     = rempty_ff;
   assign rsp_is_exhausted = rexh_ff;

   // compaction only ever touches slots below the count
   a_shift_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == iqr_pkg::ST_SHIFT) |-> (sh_ff < count_ff) && (sh_ff != '0))
      else $error("compaction index outside stored entries");

   // the count and the cursor never exceed the store depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_w <= DEPTH_W) && (cursor_w <= DEPTH_W))
      else $error("count or cursor beyond store depth");

   // a successful put raises the count by exactly one
   a_put_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == iqr_pkg::ST_IDLE && req_valid && req_type == iqr_pkg::OP_PUT
       && count_w < eff_w) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("put did not advance the count");

   // a loaded response is presented and the block returns to idle
   a_emit: assert property (@(posedge clock) disable iff (reset)
      emit_load |=> rsp_valid_ff && (state_ff == iqr_pkg::ST_IDLE))
      else $error("response not presented after emit");

endmodule
